/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, held off during reset.
`define MPE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen while out of reset.
`define MPE_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   `MPE_ASSERT(lbl, clk, rst, !(cond), msg)

`endif

/* rtl/mpe_pkg.sv */
// Types, constants and header byte lookup for the mirror packet encapsulator.
package mpe_pkg;

   localparam logic [5:0]  HDR_ERSPAN_LEN = 6'd36;
   localparam logic [5:0]  HDR_TZSP_LEN   = 6'd5;
   localparam logic [15:0] GRE_FLAGS      = 16'h1000;
   localparam logic [15:0] GRE_PROTO      = 16'h88BE;
   localparam logic [31:0] ERSPAN_INDEX   = 32'd12345;
   localparam logic [9:0]  SESSION_MASK   = 10'h3FF;
   localparam logic [7:0]  OUTER_TTL      = 8'd64;
   localparam logic [7:0]  IP_PROTO_GRE   = 8'd47;
   localparam logic [31:0] ERSPAN_VLAN    = 32'd100;
   localparam logic [31:0] ERSPAN_COS     = 32'd5;
   // ERSPAN word one without the session id: version 1, vlan, cos, truncation bit
   localparam logic [31:0] ERSPAN_W1_BASE =
      (32'd1 << 28) | (ERSPAN_VLAN << 16) | (ERSPAN_COS << 13) | (32'd1 << 10);

   localparam logic [7:0] CSR_MODE    = 8'd0;
   localparam logic [7:0] CSR_SESSION = 8'd1;
   localparam logic [7:0] CSR_SOURCE  = 8'd2;
   localparam logic [7:0] CSR_TARGET  = 8'd3;

   localparam logic [9:0] SESSION_RESET = 10'd42;

   typedef struct packed {
      logic [9:0]  session;
      logic [31:0] source;
      logic [31:0] target;
   } cfg_type;

   // one queued item: payload byte plus what the back end needs for its header
   typedef struct packed {
      logic [7:0]  data;
      logic        start;
      logic        last;
      logic        erspan;
      logic [15:0] total_len;
      logic [31:0] seq;
   } entry_type;

   function automatic logic [7:0] hdr_byte(input logic erspan, input logic [5:0] idx,
                                           input logic [15:0] total_len,
                                           input logic [31:0] seq, input cfg_type cfg);
      logic [31:0] w1;
      logic [7:0]  b;
      w1 = ERSPAN_W1_BASE | {22'd0, cfg.session & SESSION_MASK};
      b  = 8'h00;
      if (!erspan) begin
         // TZSP: 01 01 00 01 01
         b = (idx == 6'd2) ? 8'h00 : 8'h01;
      end else begin
         unique case (idx)
            6'd0:    b = 8'h45;
            6'd2:    b = total_len[15:8];
            6'd3:    b = total_len[7:0];
            6'd8:    b = OUTER_TTL;
            6'd9:    b = IP_PROTO_GRE;
            6'd12:   b = cfg.source[31:24];
            6'd13:   b = cfg.source[23:16];
            6'd14:   b = cfg.source[15:8];
            6'd15:   b = cfg.source[7:0];
            6'd16:   b = cfg.target[31:24];
            6'd17:   b = cfg.target[23:16];
            6'd18:   b = cfg.target[15:8];
            6'd19:   b = cfg.target[7:0];
            6'd20:   b = GRE_FLAGS[15:8];
            6'd21:   b = GRE_FLAGS[7:0];
            6'd22:   b = GRE_PROTO[15:8];
            6'd23:   b = GRE_PROTO[7:0];
            6'd24:   b = seq[31:24];
            6'd25:   b = seq[23:16];
            6'd26:   b = seq[15:8];
            6'd27:   b = seq[7:0];
            6'd28:   b = w1[31:24];
            6'd29:   b = w1[23:16];
            6'd30:   b = w1[15:8];
            6'd31:   b = w1[7:0];
            6'd32:   b = ERSPAN_INDEX[31:24];
            6'd33:   b = ERSPAN_INDEX[23:16];
            6'd34:   b = ERSPAN_INDEX[15:8];
            6'd35:   b = ERSPAN_INDEX[7:0];
            default: b = 8'h00;
         endcase
      end
      return b;
   endfunction

endpackage

/* rtl/mpe_front.sv */
// Front end: register file, frame tracking, sequence numbering and queue push.
module mpe_front
   import mpe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        req_tuser,
   input  logic        req_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        queue_full,
   output logic        push,
   output entry_type   push_entry,
   output cfg_type     cfg
);

   logic        mode_ff, mode_in;
   logic [9:0]  session_ff, session_in;
   logic [31:0] source_ff, source_in;
   logic [31:0] target_ff, target_in;
   logic [31:0] seq_ff, seq_in;
   logic        in_frame_ff, in_frame_in;
   logic        accept;
   logic        csr_wr;

   assign csr_ready  = 1'b1;
   assign csr_wr     = csr_valid & csr_ready;
   assign req_tready = !queue_full;
   assign accept     = req_tvalid & req_tready;
   // stray bytes outside a frame are taken and dropped
   assign push       = accept & (req_tuser | in_frame_ff);

   assign cfg = '{session: session_ff, source: source_ff, target: target_ff};

   always_comb begin
      push_entry.data      = req_tdata[7:0];
      push_entry.start     = req_tuser;
      push_entry.last      = req_tlast;
      push_entry.erspan    = mode_ff;
      push_entry.total_len = 16'({10'd0, HDR_ERSPAN_LEN} + req_tdata[23:8]);
      push_entry.seq       = seq_ff;
   end

   always_comb begin
      mode_in    = mode_ff;
      session_in = session_ff;
      source_in  = source_ff;
      target_in  = target_ff;
      if (csr_wr) begin
         unique case (csr_index)
            CSR_MODE:    mode_in    = csr_data[0];
            CSR_SESSION: session_in = csr_data[9:0] & SESSION_MASK;
            CSR_SOURCE:  source_in  = csr_data;
            CSR_TARGET:  target_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      seq_in      = seq_ff;
      in_frame_in = in_frame_ff;
      if (push) begin
         in_frame_in = !req_tlast;
         if (req_tuser && mode_ff) seq_in = seq_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= 1'b0;
         session_ff  <= SESSION_RESET;
         source_ff   <= '0;
         target_ff   <= '0;
         seq_ff      <= '0;
         in_frame_ff <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         session_ff  <= session_in;
         source_ff   <= source_in;
         target_ff   <= target_in;
         seq_ff      <= seq_in;
         in_frame_ff <= in_frame_in;
      end
   end

endmodule

/* rtl/mpe_queue.sv */
// Short queue of classified items between front and back end.
`include "assert_macros.svh"
module mpe_queue
   import mpe_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      full,
   output logic      empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == FULL_CNT);
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (push && !pop)      count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

   `MPE_ASSERT_NEVER(a_no_overflow, clock, reset, push && full, "queue push while full")
   `MPE_ASSERT_NEVER(a_no_underflow, clock, reset, pop && empty, "queue pop while empty")
   `MPE_ASSERT(a_count_step, clock, reset, (push && !pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)), "queue count did not advance")

endmodule

/* rtl/mpe_back.sv */
// Back end: header byte sequencing and registered output stage.
`include "assert_macros.svh"
module mpe_back
   import mpe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  entry_type  head,
   input  logic       empty,
   input  cfg_type    cfg,
   output logic       pop,
   input  logic       rsp_tready,
   output logic       rsp_tvalid,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tuser,
   output logic       rsp_tlast
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       first_ff, first_in;
   logic       last_ff, last_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [5:0] hdr_len;
   logic       out_free;
   logic       emit;
   logic       in_hdr;

   assign hdr_len  = head.erspan ? HDR_ERSPAN_LEN : HDR_TZSP_LEN;
   assign out_free = !valid_ff || rsp_tready;
   assign emit     = !empty && out_free;
   assign in_hdr   = head.start && (cnt_ff < hdr_len);
   assign pop      = emit && !in_hdr;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      first_in = first_ff;
      last_in  = last_ff;
      cnt_in   = cnt_ff;
      if (out_free) valid_in = 1'b0;
      if (emit) begin
         valid_in = 1'b1;
         if (in_hdr) begin
            data_in  = hdr_byte(head.erspan, cnt_ff, head.total_len, head.seq, cfg);
            first_in = (cnt_ff == '0);
            last_in  = 1'b0;
            cnt_in   = cnt_ff + 6'd1;
         end else begin
            data_in  = head.data;
            first_in = 1'b0;
            last_in  = head.last;
            cnt_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      first_ff <= first_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = first_ff;
   assign rsp_tlast  = last_ff;

   `MPE_ASSERT_NEVER(a_cnt_range, clock, reset, cnt_ff > HDR_ERSPAN_LEN, "header count out of range")
   `MPE_ASSERT_NEVER(a_first_not_last, clock, reset, valid_ff && first_ff && last_ff, "header byte marked last")
   `MPE_ASSERT(a_pop_clears_cnt, clock, reset, pop |=> (cnt_ff == '0), "header count not cleared after payload byte")

endmodule

/* rtl/mirror_packet_encapsulator_unit.sv */
// Mirror packet encapsulator: ERSPAN type II over GRE/IPv4 or TZSP, one byte per item.
//
// req_ carries captured frame bytes: tuser marks the first byte of a frame, tlast the
// last, and the frame length rides in tdata beside the byte on the first item.
// rsp_ carries the encapsulated packet a byte per item: tuser marks its first header
// byte, tlast the byte that closed the frame. Bytes arriving outside a frame are dropped.
// csr_ writes the mode, session id and the IPv4 source and target addresses; write only
// while the block is idle. Writes are always taken (csr_ready is tied high).
// An accepted item is written into the queue, and the back end moves it on into the rsp_
// output register when that is free. Throughput is one output byte per cycle while
// rsp_tready is high, set by the single output register; a start byte adds 36 (ERSPAN) or 5 (TZSP) header bytes.
// Input is taken at one byte per cycle while the QUEUE_DEPTH entry queue has room, so
// the queue absorbs header bursts and req_tready falls only when it fills.
// When the receiver stalls, the output byte holds, the queue fills and req_tready drops.
// Reset (synchronous) empties the queue, clears the output, the sequence number and the
// frame state, and restores registers to TZSP mode, session 42, addresses zero.
module mirror_packet_encapsulator_unit
   import mpe_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] frame_byte, [23:8] frame_length
   input  logic        req_tuser,   // frame_start
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tuser,   // out_first
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic      queue_full;
   logic      queue_empty;
   logic      push;
   logic      pop;
   entry_type push_entry;
   entry_type head;
   cfg_type   cfg;

   mpe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry),
      .cfg        (cfg)
   );

   mpe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   mpe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (queue_empty),
      .cfg        (cfg),
      .pop        (pop),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* verif/mirror_packet_encapsulator_unit_test.sv */
// Self-checking testbench for the ERSPAN/TZSP mirror packet encapsulator.
`timescale 1ns / 100ps

module mirror_packet_encapsulator_unit_test;
   import mpe_pkg::*;

   localparam int         ITEM_TARGET   = 420;
   localparam int         WATCHDOG_MAX  = 2000;
   localparam int         SETTLE_CYCLES = 12;
   localparam logic [7:0] CSR_NONE      = 8'hFF;  // index with no register behind it

   typedef struct {
      logic [7:0] data;
      logic       first;
      logic       last;
   } pkt_byte_type;

   // Predicts the encapsulated byte stream and checks what the block sends.
   class encap_checker;
      logic         erspan;
      logic [9:0]   session;
      logic [31:0]  source;
      logic [31:0]  target;
      logic [31:0]  seq_num;
      logic         open_frame;
      pkt_byte_type expected_bytes[$];
      int           mismatches;

      function new();
         erspan     = 1'b0;
         session    = 10'd42;
         source     = '0;
         target     = '0;
         seq_num    = '0;
         open_frame = 1'b0;
         mismatches = 0;
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= 40)
            $display("%0t: mismatch: %s", $realtime, what);
      endtask

      function void set_register(logic [7:0] index, logic [31:0] value);
         case (index)
            CSR_MODE:    erspan  = value[0];
            CSR_SESSION: session = value[9:0];
            CSR_SOURCE:  source  = value;
            CSR_TARGET:  target  = value;
            default: ;
         endcase
      endfunction

      function void take_frame_byte(logic [7:0] b, logic start, logic stop,
                                    logic [15:0] flen);
         logic [0:35][7:0] hdr;
         logic [15:0]      total;
         int               n;
         pkt_byte_type     e;
         hdr = '0;
         n   = 0;
         // byte outside any frame: dropped
         if (!start && !open_frame)
            return;
         if (start) begin
            if (erspan) begin
               total   = flen + 16'd36;
               hdr[0]  = 8'h45;
               {hdr[2], hdr[3]} = total;
               hdr[8]  = 8'd64;                // ttl
               hdr[9]  = 8'd47;                // gre
               {hdr[12], hdr[13], hdr[14], hdr[15]} = source;
               {hdr[16], hdr[17], hdr[18], hdr[19]} = target;
               {hdr[20], hdr[21], hdr[22], hdr[23]} = 32'h1000_88BE;
               {hdr[24], hdr[25], hdr[26], hdr[27]} = seq_num;
               // version 1, vlan 100, cos 5, truncation bit, session id
               {hdr[28], hdr[29], hdr[30], hdr[31]} = 32'h1064_A400 | {22'd0, session};
               {hdr[32], hdr[33], hdr[34], hdr[35]} = 32'd12345;
               seq_num = seq_num + 32'd1;
               n = 36;
            end else begin
               hdr[0:4] = {8'h01, 8'h01, 8'h00, 8'h01, 8'h01};
               n = 5;
            end
            for (int i = 0; i < n; i++) begin
               e.data  = hdr[i];
               e.first = (i == 0);
               e.last  = 1'b0;
               expected_bytes.push_back(e);
            end
         end
         e.data  = b;
         e.first = 1'b0;
         e.last  = stop;
         expected_bytes.push_back(e);
         open_frame = !stop;
      endfunction

      task check_packet_byte(logic [7:0] b, logic first, logic last);
         pkt_byte_type e;
         if (expected_bytes.size() == 0) begin
            report($sformatf("byte %02h first %0b last %0b with nothing expected",
                             b, first, last));
            return;
         end
         e = expected_bytes.pop_front();
         if (b !== e.data)
            report($sformatf("out_byte %02h, expected %02h", b, e.data));
         if (first !== e.first)
            report($sformatf("out_first %0b, expected %0b (byte %02h)", first, e.first, b));
         if (last !== e.last)
            report($sformatf("out_last %0b, expected %0b (byte %02h)", last, e.last, b));
      endtask

      function int pending();
         return expected_bytes.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // [7:0] frame_byte, [23:8] frame_length
   logic        req_tuser;   // frame_start
   logic        req_tlast;   // frame_end
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [7:0] out_byte
   logic        rsp_tuser;   // out_first
   logic        rsp_tlast;   // out_last
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [31:0] csr_data;

   encap_checker chk;
   logic         stall_on;
   int           items_sent;
   int           quiet_cycles;

   mirror_packet_encapsulator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // handshake monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            chk.set_register(csr_index, csr_data);
         if (req_tvalid && req_tready)
            chk.take_frame_byte(req_tdata[7:0], req_tuser, req_tlast, req_tdata[23:8]);
         if (rsp_tvalid && rsp_tready)
            chk.check_packet_byte(rsp_tdata, rsp_tuser, rsp_tlast);
         if ((csr_valid && csr_ready) || (req_tvalid && req_tready) ||
             (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("mirror_packet_encapsulator_unit_test: done, errors");
            $finish;
         end
      end
   end

   // receiver: ready with random stall bursts
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (stall_on && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
            @(negedge clock);
         end
      end
   end

   task push_byte(logic [7:0] b, logic start, logic stop, logic [15:0] flen);
      @(negedge clock);
      if (stall_on && $urandom_range(0, 4) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_tdata  = {flen, b};
      req_tuser  = start;
      req_tlast  = stop;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // n bytes; the length field is only meaningful on the start byte
   task send_frame(int n, logic [15:0] flen, logic close);
      for (int i = 0; i < n; i++)
         push_byte(8'($urandom), i == 0, close && (i == n - 1),
                   (i == 0) ? flen : 16'($urandom));
   endtask

   task wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (chk.pending() != 0) @(posedge clock);
      // dropped bytes never enter the queue; any byte sent beyond the expected ones is still seen here
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_reg(logic [7:0] index, logic [31:0] value);
      @(negedge clock);
      csr_index = index;
      csr_data  = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 3))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick_length(int n);
      case ($urandom_range(0, 9))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return 16'd65499;
         3:       return 16'($urandom);
         default: return n[15:0];
      endcase
   endfunction

   initial begin
      int n;
      chk          = new();
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      req_tlast    = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = CSR_MODE;
      csr_data     = '0;
      stall_on     = 1'b1;
      items_sent   = 0;
      quiet_cycles = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: TZSP, stray byte, single-byte frame, short frame
      push_byte(8'hFF, 1'b0, 1'b0, 16'hFFFF);
      push_byte(8'h00, 1'b1, 1'b1, 16'd1);
      push_byte(8'hA5, 1'b1, 1'b0, 16'd0);
      push_byte(8'h5A, 1'b0, 1'b1, 16'd2);
      wait_drained();

      write_reg(CSR_MODE, 32'd1);
      write_reg(CSR_SESSION, 32'hFFFF_FFFF);
      write_reg(CSR_SOURCE, 32'hFFFF_FFFF);
      write_reg(CSR_TARGET, 32'h0000_0000);
      write_reg(CSR_NONE, 32'h1234_5678);
      push_byte(8'hFF, 1'b1, 1'b1, 16'd65499);
      // total length wraps
      push_byte(8'h11, 1'b1, 1'b0, 16'hFFFF);
      push_byte(8'h22, 1'b0, 1'b0, 16'h0000);
      push_byte(8'h33, 1'b0, 1'b1, 16'h0000);
      // new start while a frame is still open
      push_byte(8'h44, 1'b1, 1'b0, 16'd9);
      push_byte(8'h55, 1'b0, 1'b0, 16'd0);
      push_byte(8'h66, 1'b1, 1'b0, 16'd2);
      push_byte(8'h77, 1'b0, 1'b1, 16'd0);
      push_byte(8'h88, 1'b0, 1'b1, 16'd0);
      wait_drained();

      write_reg(CSR_SESSION, 32'd0);
      write_reg(CSR_SOURCE, 32'h0000_0000);
      write_reg(CSR_TARGET, 32'hFFFF_FFFF);
      push_byte(8'h01, 1'b1, 1'b1, 16'd0);
      // leave a frame open across a mode change
      push_byte(8'h02, 1'b1, 1'b0, 16'd3);
      wait_drained();
      write_reg(CSR_MODE, 32'd0);
      push_byte(8'h03, 1'b0, 1'b0, 16'd0);
      push_byte(8'h04, 1'b0, 1'b1, 16'd0);
      push_byte(8'h05, 1'b1, 1'b1, 16'd1);

      for (int phase = 0; phase < 6; phase++) begin
         wait_drained();
         write_reg(CSR_MODE, (phase % 2 == 0) ? 32'd1 : {$urandom} & 32'h1);
         write_reg(CSR_SESSION, pick_word());
         write_reg(CSR_SOURCE, pick_word());
         write_reg(CSR_TARGET, pick_word());
         // no idling at all in the last part
         stall_on = (phase < 5);
         while (items_sent < (phase + 1) * ITEM_TARGET / 6) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            case ($urandom_range(0, 9))
               7:       repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0,
                                                                 1'($urandom_range(0, 1)),
                                                                 16'($urandom));
               8:       send_frame(n, pick_length(n), 1'b0);
               default: send_frame(n, pick_length(n), 1'b1);
            endcase
            if (phase == 2 && items_sent > 3 * ITEM_TARGET / 6 - 20 && chk.pending() != 0)
               wait_drained();
         end
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      while (chk.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (chk.pending() != 0)
         chk.report($sformatf("%0d bytes never arrived", chk.pending()));
      if (chk.mismatches == 0)
         $display("mirror_packet_encapsulator_unit_test: done, clean");
      else
         $display("mirror_packet_encapsulator_unit_test: done, errors");
      $finish;
   end

endmodule
